// File: hdl/spi9_pkg.sv
`timescale 1ns / 1ps
// spi9_pkg: types and constants of the nine-bit three-wire spi master
// no dependencies

package spi9_pkg;

	localparam int DATA_BITS   = 8;
	localparam int WORD_W      = DATA_BITS + 1;
	localparam int BIT_CNT_W   = 4;
	localparam int DELAY_W     = 16;
	localparam int TURN_W      = 4;
	localparam int ACTION_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(20);
	localparam logic [TURN_W-1:0]  TURN_RESET  = TURN_W'(3);

	localparam logic [ACTION_W-1:0] ACT_TICK  = ACTION_W'(0);
	localparam logic [ACTION_W-1:0] ACT_WRITE = ACTION_W'(1);
	localparam logic [ACTION_W-1:0] ACT_READ  = ACTION_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_UNITS  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_READ,
		CMD_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [WORD_W-1:0] word;
		logic              sda_in;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_ticks;
		logic [TURN_W-1:0]  turnaround_units;
	} cfg_regs_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_CS,
		PH_W_DCH,
		PH_W_DCL,
		PH_W_BITL,
		PH_W_BITH,
		PH_R_SDA,
		PH_R_CKH,
		PH_R_CKL,
		PH_R_TURN,
		PH_R_HIGH,
		PH_R_LOW,
		PH_TAIL,
		PH_END
	} phase_t;

endpackage

// File: hdl/spi9_if.sv
`timescale 1ns / 1ps
// spi9 channel interfaces: request, response and configuration write
// depends on spi9_pkg

interface spi9_req_if;
	logic                             valid;
	logic                             ready;
	logic [spi9_pkg::ACTION_W-1:0]    action;
	logic [spi9_pkg::WORD_W-1:0]      word;
	logic                             sda_in;

	modport source (output valid, action, word, sda_in, input ready);
	modport sink   (input valid, action, word, sda_in, output ready);
endinterface

interface spi9_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             scl;
	logic                             sda_out;
	logic                             sda_drive;
	logic                             csb;
	logic                             busy_res;
	logic                             write_done;
	logic                             read_valid;
	logic [spi9_pkg::DATA_BITS-1:0]   read_byte;

	modport source (output valid, scl, sda_out, sda_drive, csb, busy_res, write_done,
		read_valid, read_byte, input ready);
	modport sink   (input valid, scl, sda_out, sda_drive, csb, busy_res, write_done,
		read_valid, read_byte, output ready);
endinterface

interface spi9_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spi9_pkg::CFG_IDX_W-1:0]    index;
	logic [spi9_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/spi9_front.sv
`timescale 1ns / 1ps
// spi9_front: accepts request transactions, decodes the action and queues commands
// depends on spi9_pkg and spi9_if

module spi9_front (
	input  logic                   clk,
	input  logic                   arst_n,
	spi9_req_if.sink               req,
	input  logic                   pop,
	output spi9_pkg::queue_head_t  head
);

	spi9_pkg::cmd_t     mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               do_pop;
	spi9_pkg::cmd_t     cmd_in;

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign do_pop    = pop && (count_q != 2'd0);

	always_comb begin
		cmd_in.word   = req.word;
		cmd_in.sda_in = req.sda_in;
		unique case (req.action)
			spi9_pkg::ACT_TICK:  cmd_in.kind = spi9_pkg::CMD_TICK;
			spi9_pkg::ACT_WRITE: cmd_in.kind = spi9_pkg::CMD_WRITE;
			spi9_pkg::ACT_READ:  cmd_in.kind = spi9_pkg::CMD_READ;
			default:             cmd_in.kind = spi9_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end else begin
				count_q <= count_q;
			end
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = mem_q[rd_ptr_q];

endmodule

// File: hdl/spi9_seq.sv
`timescale 1ns / 1ps
// spi9_seq: frame sequencer, delay unit counter and response register
// depends on spi9_pkg and spi9_if

module spi9_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spi9_pkg::queue_head_t  head,
	output logic                   pop,
	input  spi9_pkg::cfg_regs_t    cfg_regs,
	spi9_rsp_if.source             rsp
);

	localparam int CNT_W = spi9_pkg::DELAY_W + 1;
	localparam int DB    = spi9_pkg::DATA_BITS;

	spi9_pkg::phase_t                     phase_q, phase_d;
	logic                                 reading_q, reading_d;
	logic [spi9_pkg::BIT_CNT_W-1:0]       bit_count_q, bit_count_d;
	logic [spi9_pkg::WORD_W-1:0]          shift_q, shift_d;
	logic [spi9_pkg::DELAY_W-1:0]         unit_cnt_q, unit_cnt_d;
	logic [DB-1:0]                        rx_q, rx_d;
	logic                                 scl_q, scl_d;
	logic                                 sda_q, sda_d;
	logic                                 cs_q, cs_d;
	logic                                 drive_q, drive_d;

	logic                                 rsp_valid_q;
	logic                                 is_tick;
	logic                                 start;
	logic                                 advance;
	logic                                 unit_hit;
	logic [CNT_W-1:0]                     cnt_inc;
	logic [CNT_W-1:0]                     unit_lim;
	logic [spi9_pkg::WORD_W-1:0]          shift_next;
	logic [spi9_pkg::BIT_CNT_W-1:0]       bc_inc;
	logic [spi9_pkg::BIT_CNT_W-1:0]       bits_total;
	logic                                 wdone;
	logic                                 rvalid;

	assign pop        = head.valid && (!rsp_valid_q || rsp.ready);
	assign is_tick    = head.cmd.kind == spi9_pkg::CMD_TICK;
	assign start      = (phase_q == spi9_pkg::PH_IDLE) &&
		((head.cmd.kind == spi9_pkg::CMD_WRITE) || (head.cmd.kind == spi9_pkg::CMD_READ));
	assign advance    = is_tick && (phase_q != spi9_pkg::PH_IDLE) &&
		(phase_q != spi9_pkg::PH_R_HIGH);
	assign cnt_inc    = {1'b0, unit_cnt_q} + CNT_W'(1);
	assign unit_lim   = (cfg_regs.delay_ticks == '0) ? CNT_W'(1) : {1'b0, cfg_regs.delay_ticks};
	assign unit_hit   = cnt_inc >= unit_lim;
	assign shift_next = {1'b0, shift_q[DB-2:0], 1'b0};
	assign bc_inc     = bit_count_q + spi9_pkg::BIT_CNT_W'(1);
	assign bits_total = spi9_pkg::BIT_CNT_W'(DB);

	// next state
	always_comb begin
		phase_d     = phase_q;
		reading_d   = reading_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		unit_cnt_d  = unit_cnt_q;
		rx_d        = rx_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		cs_d        = cs_q;
		drive_d     = drive_q;
		priority if (start) begin
			reading_d   = head.cmd.kind == spi9_pkg::CMD_READ;
			shift_d     = head.cmd.word;
			unit_cnt_d  = '0;
			bit_count_d = '0;
			cs_d        = 1'b0;
			scl_d       = 1'b0;
			phase_d     = spi9_pkg::PH_CS;
		end else if (is_tick && phase_q == spi9_pkg::PH_R_HIGH) begin
			scl_d      = 1'b0;
			unit_cnt_d = '0;
			phase_d    = spi9_pkg::PH_R_LOW;
		end else if (advance) begin
			unit_cnt_d = unit_hit ? '0 : cnt_inc[spi9_pkg::DELAY_W-1:0];
			if (unit_hit) begin
				unique case (phase_q)
					spi9_pkg::PH_CS: begin
						drive_d = 1'b1;
						if (reading_q) begin
							sda_d   = 1'b1;
							phase_d = spi9_pkg::PH_R_SDA;
						end else begin
							sda_d   = shift_q[DB];
							scl_d   = 1'b1;
							phase_d = spi9_pkg::PH_W_DCH;
						end
					end
					spi9_pkg::PH_W_DCH: begin
						scl_d   = 1'b0;
						phase_d = spi9_pkg::PH_W_DCL;
					end
					spi9_pkg::PH_W_DCL: begin
						bit_count_d = '0;
						sda_d       = shift_q[DB-1];
						phase_d     = spi9_pkg::PH_W_BITL;
					end
					spi9_pkg::PH_W_BITL: begin
						scl_d   = 1'b1;
						phase_d = spi9_pkg::PH_W_BITH;
					end
					spi9_pkg::PH_W_BITH: begin
						scl_d       = 1'b0;
						bit_count_d = bc_inc;
						shift_d     = shift_next;
						if (bc_inc < bits_total) begin
							sda_d   = shift_next[DB-1];
							phase_d = spi9_pkg::PH_W_BITL;
						end else begin
							sda_d   = 1'b0;
							phase_d = spi9_pkg::PH_TAIL;
						end
					end
					spi9_pkg::PH_R_SDA: begin
						scl_d   = 1'b1;
						phase_d = spi9_pkg::PH_R_CKH;
					end
					spi9_pkg::PH_R_CKH: begin
						scl_d   = 1'b0;
						phase_d = spi9_pkg::PH_R_CKL;
					end
					spi9_pkg::PH_R_CKL: begin
						drive_d     = 1'b0;
						bit_count_d = '0;
						rx_d        = '0;
						phase_d     = spi9_pkg::PH_R_TURN;
					end
					spi9_pkg::PH_R_TURN: begin
						bit_count_d = bc_inc;
						if (bc_inc == cfg_regs.turnaround_units) begin
							// first bit sampled right after the turnaround
							scl_d       = 1'b1;
							rx_d        = {rx_q[DB-2:0], head.cmd.sda_in};
							bit_count_d = spi9_pkg::BIT_CNT_W'(1);
							phase_d     = spi9_pkg::PH_R_HIGH;
						end
					end
					spi9_pkg::PH_R_LOW: begin
						if (bit_count_q < bits_total) begin
							scl_d       = 1'b1;
							rx_d        = {rx_q[DB-2:0], head.cmd.sda_in};
							bit_count_d = bc_inc;
							phase_d     = spi9_pkg::PH_R_HIGH;
						end else begin
							drive_d = 1'b1;
							sda_d   = 1'b0;
							phase_d = spi9_pkg::PH_TAIL;
						end
					end
					spi9_pkg::PH_TAIL: begin
						cs_d    = 1'b1;
						phase_d = spi9_pkg::PH_END;
					end
					spi9_pkg::PH_END: begin
						phase_d = spi9_pkg::PH_IDLE;
					end
					default: begin
						phase_d = spi9_pkg::PH_IDLE;
					end
				endcase
			end
		end else begin
			phase_d = phase_q;
		end
	end

	// outputs of the transaction
	always_comb begin
		wdone  = 1'b0;
		rvalid = 1'b0;
		if (advance && unit_hit && phase_q == spi9_pkg::PH_END) begin
			wdone  = !reading_q;
			rvalid = reading_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= spi9_pkg::PH_IDLE;
			reading_q   <= 1'b0;
			bit_count_q <= '0;
			shift_q     <= '0;
			unit_cnt_q  <= '0;
			rx_q        <= '0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b1;
			cs_q        <= 1'b1;
			drive_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				reading_q   <= reading_d;
				bit_count_q <= bit_count_d;
				shift_q     <= shift_d;
				unit_cnt_q  <= unit_cnt_d;
				rx_q        <= rx_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				cs_q        <= cs_d;
				drive_q     <= drive_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp.scl        <= scl_d;
			rsp.sda_out    <= drive_d & sda_d;
			rsp.sda_drive  <= drive_d;
			rsp.csb        <= cs_d;
			rsp.busy_res   <= phase_d != spi9_pkg::PH_IDLE;
			rsp.write_done <= wdone;
			rsp.read_valid <= rvalid;
			rsp.read_byte  <= rvalid ? rx_d : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

// File: hdl/nine_bit_three_wire_spi_master_unit.sv
`timescale 1ns / 1ps
// nine_bit_three_wire_spi_master_unit: top level of the nine-bit three-wire spi master
// depends on spi9_pkg, spi9_if, spi9_front and spi9_seq
//
//   channel  dir  fields
//   req      in   action[1:0], word[8:0], sda_in
//   rsp      out  scl, sda_out, sda_drive, csb, busy_res, write_done, read_valid, read_byte[7:0]
//   cfg      in   index[0], data[15:0]
//
// one transaction per cycle sustained while rsp is ready; each request transaction gives exactly one response
// each command passes through the two-entry command queue, then the response register
// the sequencer updates pin state for each popped command; tick phase steps are set by the unit counter compare
// arst_n clears the queue, sequencer state and pin state (scl low, sda high, csb high, driven)
// a stalled rsp holds the response; the queue keeps taking requests until it holds two

module nine_bit_three_wire_spi_master_unit (
	input  logic         clk,
	input  logic         arst_n,
	spi9_req_if.sink     req,
	spi9_rsp_if.source   rsp,
	spi9_cfg_if.sink     cfg
);

	spi9_pkg::cfg_regs_t    cfg_regs_q;
	spi9_pkg::queue_head_t  head;
	logic                   pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.delay_ticks      <= spi9_pkg::DELAY_RESET;
			cfg_regs_q.turnaround_units <= spi9_pkg::TURN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spi9_pkg::REG_DELAY_TICKS: begin
					cfg_regs_q.delay_ticks <= cfg.data;
				end
				spi9_pkg::REG_TURN_UNITS: begin
					cfg_regs_q.turnaround_units <= cfg.data[spi9_pkg::TURN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	spi9_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	spi9_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.cfg_regs (cfg_regs_q),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.write_done && rsp.read_valid))
		else $error("write_done and read_valid together");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.sda_drive) |-> !rsp.sda_out)
		else $error("sda_out high while line released");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.write_done || rsp.read_valid)) |-> (!rsp.busy_res && rsp.csb))
		else $error("frame end while still busy or selected");

	a_idle_deselect: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.busy_res) |-> (rsp.csb && rsp.sda_drive))
		else $error("idle with chip select low or line released");
`endif

endmodule
